// ===== design/cdr_pkg.sv =====
`timescale 1ns / 1ps
package cdr_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;
    localparam int LIM_W      = 10;
    localparam int LIM2_W     = 2 * LIM_W;
    localparam int SUM_W      = 30;
    localparam int C_W        = 16;
    localparam int DIV_STAGES = C_W;
    localparam int DIVD_W     = SUM_W + 7;
    localparam int PROD_W     = 26;

    localparam logic [CFG_IDX_W-1:0] REG_NEW_RED   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NEW_GREEN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NEW_BLUE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OLD_RED   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OLD_GREEN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OLD_BLUE  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT     = 3'd6;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] alpha;
        logic       frame_end;
    } t_pix;

    typedef struct packed {
        logic [7:0]        new_red;
        logic [7:0]        new_green;
        logic [7:0]        new_blue;
        logic [7:0]        old_red;
        logic [7:0]        old_green;
        logic [7:0]        old_blue;
        logic [LIM2_W-1:0] lim2;
    } t_cfg;

endpackage

// ===== design/color_distance_replace.sv =====
`timescale 1ns / 1ps
// pipeline: 4 distance, 16 divide and 2 blend stages from input transfer to output transfer
// throughput: one pixel per cycle unless stalled; every stage fills its bubble in a stall
// the divide part is a 16-stage restoring divider, one quotient bit per stage
// reset (synchronous, active low) clears all valid bits and sets every
// configuration register to zero
module color_distance_replace
    import cdr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [7:0]            i_pixel_blue,
    input  logic [7:0]            i_pixel_green,
    input  logic [7:0]            i_pixel_red,
    input  logic [7:0]            i_pixel_alpha,
    input  logic                  i_frame_end,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [7:0]            o_out_blue,
    output logic [7:0]            o_out_green,
    output logic [7:0]            o_out_red,
    output logic [7:0]            o_out_alpha,
    output logic                  o_replaced,
    output logic                  o_frame_end_out
);

    t_cfg             cfg;
    t_pix             in_pix;
    t_pix             dist_pix;
    t_pix             div_pix;
    t_pix             out_pix;
    logic             dist_ready, dist_valid, dist_match;
    logic [SUM_W-1:0] dist_sum;
    logic             div_ready, div_valid, div_match;
    logic [C_W-1:0]   div_quot;
    logic             blend_ready;

    assign in_pix.blue      = i_pixel_blue;
    assign in_pix.green     = i_pixel_green;
    assign in_pix.red       = i_pixel_red;
    assign in_pix.alpha     = i_pixel_alpha;
    assign in_pix.frame_end = i_frame_end;

    cdr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    cdr_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (i_valid),
        .o_ready (dist_ready),
        .i_pix   (in_pix),
        .o_valid (dist_valid),
        .i_adv   (div_ready),
        .o_sum   (dist_sum),
        .o_match (dist_match),
        .o_pix   (dist_pix)
    );

    cdr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_lim2  (cfg.lim2),
        .i_valid (dist_valid),
        .o_ready (div_ready),
        .i_sum   (dist_sum),
        .i_match (dist_match),
        .i_pix   (dist_pix),
        .o_valid (div_valid),
        .i_adv   (blend_ready),
        .o_quot  (div_quot),
        .o_match (div_match),
        .o_pix   (div_pix)
    );

    cdr_blend u_blend (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_valid    (div_valid),
        .o_ready    (blend_ready),
        .i_quot     (div_quot),
        .i_match    (div_match),
        .i_pix      (div_pix),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_pix      (out_pix),
        .o_replaced (o_replaced)
    );

    assign o_stall         = !dist_ready;
    assign o_out_blue      = out_pix.blue;
    assign o_out_green     = out_pix.green;
    assign o_out_red       = out_pix.red;
    assign o_out_alpha     = out_pix.alpha;
    assign o_frame_end_out = out_pix.frame_end;

    a_replaced_opaque: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_replaced) |-> (o_out_alpha == ALPHA_OPAQUE))
        else $error("replaced pixel without opaque alpha");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled while output is free");

endmodule

// ===== design/cdr_cfg.sv =====
`timescale 1ns / 1ps
module cdr_cfg
    import cdr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_we,
    input  logic [CFG_IDX_W-1:0]  i_index,
    input  logic [CFG_DATA_W-1:0] i_data,
    output t_cfg                  o_cfg
);

    t_cfg              r_cfg;
    t_cfg              n_cfg;
    logic [LIM2_W-1:0] lim_sq;

    // limit is squared once at write time
    assign lim_sq = {{LIM_W{1'b0}}, i_data[LIM_W-1:0]} * {{LIM_W{1'b0}}, i_data[LIM_W-1:0]};

    always_comb begin
        n_cfg = r_cfg;
        if (i_we) begin
            unique case (i_index)
                REG_NEW_RED:   n_cfg.new_red   = i_data[7:0];
                REG_NEW_GREEN: n_cfg.new_green = i_data[7:0];
                REG_NEW_BLUE:  n_cfg.new_blue  = i_data[7:0];
                REG_OLD_RED:   n_cfg.old_red   = i_data[7:0];
                REG_OLD_GREEN: n_cfg.old_green = i_data[7:0];
                REG_OLD_BLUE:  n_cfg.old_blue  = i_data[7:0];
                REG_LIMIT:     n_cfg.lim2      = lim_sq;
                default:       n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== design/cdr_dist.sv =====
`timescale 1ns / 1ps
module cdr_dist
    import cdr_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_pix             i_pix,
    output logic             o_valid,
    input  logic             i_adv,
    output logic [SUM_W-1:0] o_sum,
    output logic             o_match,
    output t_pix             o_pix
);

    logic r_v1, r_v2, r_v3, r_v4;
    logic e1, e2, e3, e4;

    // stage 1: differences
    logic signed [8:0] r1_dr, r1_dg, r1_db;
    logic        [8:0] r1_rsum;
    t_pix              r1_pix;
    // stage 2: squares
    logic [15:0]       r2_sq_r, r2_sq_g, r2_sq_b;
    logic [8:0]        r2_rsum;
    t_pix              r2_pix;
    // stage 3: weighted sum and red-mean term
    logic [SUM_W-1:0]  r3_a;
    logic signed [26:0] r3_p;
    t_pix              r3_pix;
    // stage 4: distance and match
    logic [SUM_W-1:0]  r4_s;
    logic              r4_match;
    t_pix              r4_pix;

    logic signed [8:0]  n_dr, n_dg, n_db;
    logic signed [17:0] prod_r, prod_g, prod_b;
    logic signed [16:0] sq_diff;
    logic signed [26:0] n_p;
    logic [SUM_W-1:0]   n_a, n_s, lim_sh;

    assign e4 = !r_v4 || i_adv;
    assign e3 = !r_v3 || e4;
    assign e2 = !r_v2 || e3;
    assign e1 = !r_v1 || e2;
    assign o_ready = e1;

    assign n_dr = $signed({1'b0, i_pix.red})   - $signed({1'b0, i_cfg.old_red});
    assign n_dg = $signed({1'b0, i_pix.green}) - $signed({1'b0, i_cfg.old_green});
    assign n_db = $signed({1'b0, i_pix.blue})  - $signed({1'b0, i_cfg.old_blue});

    assign prod_r = 18'(r1_dr) * 18'(r1_dr);
    assign prod_g = 18'(r1_dg) * 18'(r1_dg);
    assign prod_b = 18'(r1_db) * 18'(r1_db);

    assign n_a = {4'b0, r2_sq_r, 10'b0} + {3'b0, r2_sq_g, 11'b0}
               + {4'b0, r2_sq_b, 10'b0} + {5'b0, r2_sq_b, 9'b0};
    assign sq_diff = $signed({1'b0, r2_sq_r}) - $signed({1'b0, r2_sq_b});
    assign n_p = 27'($signed({1'b0, r2_rsum})) * 27'(sq_diff);

    assign n_s    = r3_a + {{(SUM_W-27){r3_p[26]}}, r3_p};
    assign lim_sh = {1'b0, i_cfg.lim2, 9'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (e1) r_v1 <= i_valid;
            if (e2) r_v2 <= r_v1;
            if (e3) r_v3 <= r_v2;
            if (e4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (e1) begin
            r1_dr   <= n_dr;
            r1_dg   <= n_dg;
            r1_db   <= n_db;
            r1_rsum <= {1'b0, i_pix.red} + {1'b0, i_cfg.old_red};
            r1_pix  <= i_pix;
        end
        if (e2) begin
            r2_sq_r <= prod_r[15:0];
            r2_sq_g <= prod_g[15:0];
            r2_sq_b <= prod_b[15:0];
            r2_rsum <= r1_rsum;
            r2_pix  <= r1_pix;
        end
        if (e3) begin
            r3_a   <= n_a;
            r3_p   <= n_p;
            r3_pix <= r2_pix;
        end
        if (e4) begin
            r4_s     <= n_s;
            r4_match <= (i_cfg.lim2 != '0) && (n_s < lim_sh);
            r4_pix   <= r3_pix;
        end
    end

    assign o_valid = r_v4;
    assign o_sum   = r4_s;
    assign o_match = r4_match;
    assign o_pix   = r4_pix;

endmodule

// ===== design/cdr_div.sv =====
`timescale 1ns / 1ps
module cdr_div
    import cdr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [LIM2_W-1:0] i_lim2,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [SUM_W-1:0]  i_sum,
    input  logic              i_match,
    input  t_pix              i_pix,
    output logic              o_valid,
    input  logic              i_adv,
    output logic [C_W-1:0]    o_quot,
    output logic              o_match,
    output t_pix              o_pix
);

    logic [DIV_STAGES-1:0] r_v;
    logic [DIV_STAGES-1:0] r_match;
    logic [DIV_STAGES-1:0] e;
    logic [DIVD_W-1:0]     r_rem [DIV_STAGES];
    logic [C_W-1:0]        r_q   [DIV_STAGES];
    t_pix                  r_pix [DIV_STAGES];
    logic [DIVD_W-1:0]     div_ext;

    assign div_ext = {{(DIVD_W-LIM2_W){1'b0}}, i_lim2};

    genvar j;
    generate
        for (j = 0; j < DIV_STAGES; j++) begin : g_stage
            logic              v_in;
            logic              m_in;
            logic [DIVD_W-1:0] rem_in;
            logic [C_W-1:0]    q_in;
            t_pix              pix_in;
            logic [DIVD_W-1:0] dsh;
            logic              ge;

            if (j == 0) begin : g_first
                assign v_in   = i_valid;
                assign m_in   = i_match;
                assign rem_in = {i_sum, 7'b0};
                assign q_in   = '0;
                assign pix_in = i_pix;
            end else begin : g_next
                assign v_in   = r_v[j-1];
                assign m_in   = r_match[j-1];
                assign rem_in = r_rem[j-1];
                assign q_in   = r_q[j-1];
                assign pix_in = r_pix[j-1];
            end

            if (j == DIV_STAGES - 1) begin : g_last_en
                assign e[j] = !r_v[j] || i_adv;
            end else begin : g_mid_en
                assign e[j] = !r_v[j] || e[j+1];
            end

            // one quotient bit per stage, most significant first
            assign dsh = div_ext << (C_W - 1 - j);
            assign ge  = rem_in >= dsh;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[j] <= 1'b0;
                end else if (e[j]) begin
                    r_v[j] <= v_in;
                end
            end

            always_ff @(posedge i_clk) begin
                if (e[j]) begin
                    r_rem[j]   <= ge ? rem_in - dsh : rem_in;
                    r_q[j]     <= {q_in[C_W-2:0], ge};
                    r_match[j] <= m_in;
                    r_pix[j]   <= pix_in;
                end
            end
        end
    endgenerate

    assign o_ready = e[0];
    assign o_valid = r_v[DIV_STAGES-1];
    assign o_quot  = r_q[DIV_STAGES-1];
    assign o_match = r_match[DIV_STAGES-1];
    assign o_pix   = r_pix[DIV_STAGES-1];

endmodule

// ===== design/cdr_blend.sv =====
`timescale 1ns / 1ps
module cdr_blend
    import cdr_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_cfg           i_cfg,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [C_W-1:0] i_quot,
    input  logic           i_match,
    input  t_pix           i_pix,
    output logic           o_valid,
    input  logic           i_stall,
    output t_pix           o_pix,
    output logic           o_replaced
);

    logic r_v1, r_v2;
    logic e1, e2;

    logic signed [PROD_W-1:0] r1_prod [3];
    logic                     r1_match;
    t_pix                     r1_pix;

    t_pix r2_pix;
    logic r2_replaced;

    logic [7:0]               src_in [3];
    logic [7:0]               nw     [3];
    logic signed [PROD_W-1:0] n_prod [3];
    logic [7:0]               blended [3];
    t_pix                     n_out;

    assign e2 = !r_v2 || !i_stall;
    assign e1 = !r_v1 || e2;
    assign o_ready = e1;

    assign src_in[0] = i_pix.blue;
    assign src_in[1] = i_pix.green;
    assign src_in[2] = i_pix.red;
    assign nw[0]     = i_cfg.new_blue;
    assign nw[1]     = i_cfg.new_green;
    assign nw[2]     = i_cfg.new_red;

    always_comb begin
        logic signed [8:0]        diff;
        logic signed [PROD_W-1:0] biased;
        logic signed [9:0]        t;
        logic signed [10:0]       v;
        for (int k = 0; k < 3; k++) begin
            diff      = $signed({1'b0, src_in[k]}) - $signed({1'b0, nw[k]});
            n_prod[k] = PROD_W'(diff) * PROD_W'($signed({1'b0, i_quot}));
            // truncate toward zero
            biased = r1_prod[k] + (r1_prod[k][PROD_W-1] ? PROD_W'(65535) : PROD_W'(0));
            t      = biased[PROD_W-1:C_W];
            v      = $signed({3'b0, nw[k]}) + $signed({t[9], t});
            if (v[10]) begin
                blended[k] = 8'h00;
            end else if (v[9:8] != 2'b00) begin
                blended[k] = 8'hFF;
            end else begin
                blended[k] = v[7:0];
            end
        end
    end

    always_comb begin
        n_out = r1_pix;
        if (r1_match) begin
            n_out.blue  = blended[0];
            n_out.green = blended[1];
            n_out.red   = blended[2];
            n_out.alpha = ALPHA_OPAQUE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (e1) r_v1 <= i_valid;
            if (e2) r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (e1) begin
            r1_prod[0] <= n_prod[0];
            r1_prod[1] <= n_prod[1];
            r1_prod[2] <= n_prod[2];
            r1_match   <= i_match;
            r1_pix     <= i_pix;
        end
        if (e2) begin
            r2_pix      <= n_out;
            r2_replaced <= r1_match;
        end
    end

    assign o_valid    = r_v2;
    assign o_pix      = r2_pix;
    assign o_replaced = r2_replaced;

endmodule
